// ----- src/wbfu_pkg.sv -----
// Shared types and constants of the word bit-field unit.
package wbfu_pkg;

    localparam int WORD_W = 48;

    localparam logic [WORD_W-1:0] FLAG_MASK = 48'h8000_0000_0000;
    localparam logic [WORD_W-1:0] NUM_MASK  = 48'h7FFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] SIGN_MASK = 48'h4000_0000_0000;

    // Bit positions in a word, counted from the flag end.
    localparam logic [5:0] BITS_PER_CHAR = 6'd6;
    localparam logic [5:0] WORD_BITS     = 6'd48;

    // Command codes; 14 and 15 are unused and change nothing.
    typedef enum logic [3:0] {
        CMD_DIAL_A  = 4'd0,
        CMD_DIAL_B  = 4'd1,
        CMD_XFER    = 4'd2,
        CMD_CMP_LOW = 4'd3,
        CMD_CMP_EQ  = 4'd4,
        CMD_NEGATE  = 4'd5,
        CMD_OR      = 4'd6,
        CMD_AND     = 4'd7,
        CMD_EQV     = 4'd8,
        CMD_MKOP    = 4'd9,
        CMD_MKDESC  = 4'd10,
        CMD_SETNEG  = 4'd11,
        CMD_CHSIGN  = 4'd12,
        CMD_SETPOS  = 4'd13
    } cmd_t;

    // The four dial registers.
    typedef struct packed {
        logic [2:0] src_char;
        logic [2:0] src_bit;
        logic [2:0] dst_char;
        logic [2:0] dst_bit;
    } dial_t;

    // One result item.
    typedef struct packed {
        logic              b_kept;
        logic              a_kept;
        logic [WORD_W-1:0] b_out;
        logic [WORD_W-1:0] a_out;
    } result_t;

endpackage

// ----- src/word_bit_field_unit.sv -----
// Top level of the word bit-field unit: input register, execute, result register.
// A request passes from the input register to the result register, which drives m_tvalid.
// Throughput: one request per cycle while m_tready does not stall the result register;
// the input and result registers form a two-entry pipe.
// The dial registers update as a request moves from the input to the result register.
// Reset: rst_n clears both valid flags and all four dials to zero.
module word_bit_field_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // a_word[47:0], b_word[95:48], count[101:96], zeros above
    input  logic [3:0]   s_tuser,   // cmd[3:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // a_out[47:0], b_out[95:48], a_kept[96], b_kept[97], zeros
);
    import wbfu_pkg::*;

    logic              in_valid_reg;
    logic [3:0]        in_cmd_reg;
    logic [47:0]       in_a_reg;
    logic [47:0]       in_b_reg;
    logic [5:0]        in_count_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    dial_t             dial_reg;
    dial_t             dial_next;
    result_t           res_next;
    logic              out_free;
    logic              advance;
    logic              take;

    // Handshake control of the two-entry pipe.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign take     = s_tvalid && s_tready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_cmd_reg   <= s_tuser;
            in_a_reg     <= s_tdata[47:0];
            in_b_reg     <= s_tdata[95:48];
            in_count_reg <= s_tdata[101:96];
        end
    end

    // Execute logic.
    wbfu_exec u_exec (
        .cmd       (in_cmd_reg),
        .a_word    (in_a_reg),
        .b_word    (in_b_reg),
        .count     (in_count_reg),
        .dial      (dial_reg),
        .dial_next (dial_next),
        .res       (res_next)
    );

    // Dial registers and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dial_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                dial_reg <= dial_next;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_res_reg.b_kept, out_res_reg.a_kept,
                       out_res_reg.b_out, out_res_reg.a_out};

    // Dials move only when a request leaves the input register.
    a_dial_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(dial_reg))
        else $error("dial registers changed without a request");

    // A dial command with a zero count leaves the dials alone.
    a_dial_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_count_reg == 6'd0 |=> $stable(dial_reg))
        else $error("zero-count request changed the dials");

    // Compares give a single-bit answer in A.
    a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_cmd_reg == CMD_CMP_LOW || in_cmd_reg == CMD_CMP_EQ)
        |=> m_tdata[47:1] == '0)
        else $error("compare result wider than one bit");

    // A request waiting in the input register is not lost while the output stalls.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_a_reg))
        else $error("stalled request lost");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(out_res_reg))
        else $error("stalled result changed");

endmodule

// ----- src/wbfu_exec.sv -----
// Combinational execute logic: field alignment, masking and logical operations.
module wbfu_exec (
    input  logic [3:0]           cmd,
    input  logic [47:0]          a_word,
    input  logic [47:0]          b_word,
    input  logic [5:0]           count,
    input  wbfu_pkg::dial_t      dial,
    output wbfu_pkg::dial_t      dial_next,
    output wbfu_pkg::result_t    res
);
    import wbfu_pkg::*;

    logic [5:0]        p1;
    logic [5:0]        p2;
    logic [5:0]        n;
    logic [5:0]        lo;
    logic [6:0]        hi;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] aligned;
    logic              cmp_low;
    logic              cmp_eq;

    // Source and destination positions from the dials.
    assign p1 = 6'(dial.src_char) * BITS_PER_CHAR + 6'(dial.src_bit);
    assign p2 = 6'(dial.dst_char) * BITS_PER_CHAR + 6'(dial.dst_bit);

    // Field length, cut short where either run passes the low end of its word.
    always_comb
    begin
        n = count;
        if (p1 >= WORD_BITS || p2 >= WORD_BITS)
        begin
            n = 6'd0;
        end
        else
        begin
            if ((WORD_BITS - p1) < n)
            begin
                n = WORD_BITS - p1;
            end
            if ((WORD_BITS - p2) < n)
            begin
                n = WORD_BITS - p2;
            end
        end
    end

    // Field mask in destination coordinates, bits lo up to lo+n-1.
    assign lo = WORD_BITS - p2 - n;
    assign hi = 7'(lo) + 7'(n);

    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            mask[i] = (7'(i) >= 7'(lo)) && (7'(i) < hi);
        end
    end

    // Move the source field of A under the destination field of B.
    always_comb
    begin
        if (p2 >= p1)
        begin
            aligned = a_word >> (p2 - p1);
        end
        else
        begin
            aligned = a_word << (p1 - p2);
        end
    end

    assign cmp_low = ((aligned & ~b_word & mask) != '0);
    assign cmp_eq  = (((aligned ^ b_word) & mask) == '0);

    // Result selection per command.
    always_comb
    begin
        res       = '{b_kept: 1'b1, a_kept: 1'b1, b_out: b_word, a_out: a_word};
        dial_next = dial;
        case (cmd_t'(cmd))
            CMD_DIAL_A:
            begin
                if (count != 6'd0)
                begin
                    dial_next.src_char = count[5:3];
                    dial_next.src_bit  = count[2:0];
                end
            end
            CMD_DIAL_B:
            begin
                if (count != 6'd0)
                begin
                    dial_next.dst_char = count[5:3];
                    dial_next.dst_bit  = count[2:0];
                end
            end
            CMD_XFER:
            begin
                res.b_out  = (b_word & ~mask) | (aligned & mask);
                res.a_kept = 1'b0;
            end
            CMD_CMP_LOW:
            begin
                res.a_out = {{(WORD_W-1){1'b0}}, (count == 6'd0) || cmp_low};
            end
            CMD_CMP_EQ:
            begin
                res.a_out = {{(WORD_W-1){1'b0}}, (count == 6'd0) || cmp_eq};
            end
            CMD_NEGATE:
            begin
                res.a_out = a_word ^ NUM_MASK;
            end
            CMD_OR:
            begin
                res.a_out  = (a_word & NUM_MASK) | b_word;
                res.b_kept = 1'b0;
            end
            CMD_AND:
            begin
                res.a_out  = (a_word | FLAG_MASK) & b_word;
                res.b_kept = 1'b0;
            end
            CMD_EQV:
            begin
                res.b_out  = b_word ^ (~a_word & NUM_MASK);
                res.a_kept = 1'b0;
            end
            CMD_MKOP:
            begin
                res.a_out = a_word & NUM_MASK;
            end
            CMD_MKDESC:
            begin
                res.a_out = a_word | FLAG_MASK;
            end
            CMD_SETNEG:
            begin
                res.a_out = a_word | SIGN_MASK;
            end
            CMD_CHSIGN:
            begin
                res.a_out = a_word ^ SIGN_MASK;
            end
            CMD_SETPOS:
            begin
                res.a_out = a_word & ~SIGN_MASK;
            end
            default:
            begin
                res = '{b_kept: 1'b1, a_kept: 1'b1, b_out: b_word, a_out: a_word};
            end
        endcase
    end

endmodule

// ----- tb/wbfu_result_check.sv -----
// Scoreboard of the word bit-field unit: predicts each result from the requests and compares.
module wbfu_result_check (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic [3:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    output int           fail_count,
    output int           pending,
    output int           req_seen,
    output int           res_seen
);
    import wbfu_pkg::*;

    // Results still owed by the block, oldest first.
    result_t expected_results[$];
    // Our own copy of the source and destination dials.
    dial_t   dials;
    int      errors;
    int      accepted;
    int      returned;

    // Works out the result of one request from the dial positions in force.
    function automatic result_t predict_result(input cmd_t op, input logic [47:0] a,
                                               input logic [47:0] b, input logic [5:0] cnt,
                                               input dial_t d);
        result_t     r;
        int          src_pos;
        int          dst_pos;
        int          len;
        int          src_shift;
        int          dst_shift;
        logic [47:0] msk;
        logic [47:0] src_field;
        logic [47:0] dst_field;
        logic        a_keep;
        logic        b_keep;
        src_pos   = int'(d.src_char) * 6 + int'(d.src_bit);
        dst_pos   = int'(d.dst_char) * 6 + int'(d.dst_bit);
        src_field = '0;
        dst_field = '0;
        msk       = '0;
        dst_shift = 0;
        a_keep    = 1'b1;
        b_keep    = 1'b1;
        // The field is cut short where either position runs off the low end.
        len = 0;
        if (src_pos < 48 && dst_pos < 48)
        begin
            len = int'(cnt);
            if (48 - src_pos < len)
                len = 48 - src_pos;
            if (48 - dst_pos < len)
                len = 48 - dst_pos;
        end
        if (len > 0)
        begin
            msk       = (len == 48) ? '1 : ((48'd1 << len) - 48'd1);
            src_shift = 48 - src_pos - len;
            dst_shift = 48 - dst_pos - len;
            src_field = (a >> src_shift) & msk;
            dst_field = (b >> dst_shift) & msk;
        end
        case (op)
            CMD_XFER:
            begin
                if (len > 0)
                    b = (b & ~(msk << dst_shift)) | (src_field << dst_shift);
                a_keep = 1'b0;
            end
            CMD_CMP_LOW: a = (cnt == 6'd0 || (src_field & ~dst_field) != '0) ? 48'd1 : 48'd0;
            CMD_CMP_EQ:  a = (cnt == 6'd0 || src_field == dst_field) ? 48'd1 : 48'd0;
            CMD_NEGATE:  a = a ^ NUM_MASK;
            CMD_OR:
            begin
                a      = (a & NUM_MASK) | b;
                b_keep = 1'b0;
            end
            CMD_AND:
            begin
                a      = (a | FLAG_MASK) & b;
                b_keep = 1'b0;
            end
            CMD_EQV:
            begin
                b      = b ^ (~a & NUM_MASK);
                a_keep = 1'b0;
            end
            CMD_MKOP:    a = a & NUM_MASK;
            CMD_MKDESC:  a = a | FLAG_MASK;
            CMD_SETNEG:  a = a | SIGN_MASK;
            CMD_CHSIGN:  a = a ^ SIGN_MASK;
            CMD_SETPOS:  a = a & ~SIGN_MASK;
            default: ;
        endcase
        r.a_out  = a;
        r.b_out  = b;
        r.a_kept = a_keep;
        r.b_kept = b_keep;
        return r;
    endfunction

    // Reports one field that differs from the prediction.
    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Predict on each accepted request and compare on each accepted result.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        logic [5:0] cnt;
        if (!rst_n)
        begin
            expected_results.delete();
            dials      <= '0;
            errors     = 0;
            accepted   = 0;
            returned   = 0;
            fail_count <= 0;
            pending    <= 0;
            req_seen   <= 0;
            res_seen   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                cnt  = s_tdata[101:96];
                want = predict_result(cmd_t'(s_tuser), s_tdata[47:0], s_tdata[95:48], cnt,
                                      dials);
                expected_results.push_back(want);
                accepted++;
                // A dial request with a zero count leaves the dials alone.
                if (s_tuser == CMD_DIAL_A && cnt != 6'd0)
                begin
                    dials.src_char <= cnt[5:3];
                    dials.src_bit  <= cnt[2:0];
                end
                if (s_tuser == CMD_DIAL_B && cnt != 6'd0)
                begin
                    dials.dst_char <= cnt[5:3];
                    dials.dst_bit  <= cnt[2:0];
                end
            end
            if (m_tvalid && m_tready)
            begin
                returned++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, got %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("a_out", want.a_out, m_tdata[47:0]);
                    check_field("b_out", want.b_out, m_tdata[95:48]);
                    check_field("a_kept", 48'(want.a_kept), 48'(m_tdata[96]));
                    check_field("b_kept", 48'(want.b_kept), 48'(m_tdata[97]));
                end
            end
            pending    <= expected_results.size();
            fail_count <= errors;
            req_seen   <= accepted;
            res_seen   <= returned;
        end
    end

endmodule

// ----- tb/tb_word_bit_field_unit.sv -----
// Testbench top of the word bit-field unit: clock, reset, request stimulus and verdict.
module tb_word_bit_field_unit;
    import wbfu_pkg::*;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          PHASE_ITEMS    = 406;
    localparam int          HOLD_CYCLES    = 64;
    localparam logic [3:0]  CMD_UNUSED_LO  = 4'd14;
    localparam logic [3:0]  CMD_UNUSED_HI  = 4'd15;
    localparam logic [47:0] ALL_ONES       = '1;

    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata  = '0;
    logic [3:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;

    int fail_count;
    int pending;
    int req_seen;
    int res_seen;
    int sent         = 0;
    int send_idle    = 0;
    int recv_stall   = 0;
    int hold_asks    = 0;
    int hold_done    = 0;
    int cycle_count  = 0;
    int idle_mix[4]  = '{0, 61, 0, 19};
    int stall_mix[4] = '{0, 0, 61, 19};

    always #5 clk = ~clk;

    word_bit_field_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wbfu_result_check result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending),
        .req_seen   (req_seen),
        .res_seen   (res_seen)
    );

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done++;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Mostly random words, with the all-zero, all-one and flag-plus-random-sign patterns mixed in.
    function automatic logic [47:0] rand_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            2: return FLAG_MASK | (r[47:0] & SIGN_MASK);
            default: return r[47:0];
        endcase
    endfunction

    // Offers one request, after a random gap, and waits until it is taken.
    task automatic send_request(input logic [3:0] op, input logic [47:0] a,
                                input logic [47:0] b, input logic [5:0] cnt);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, cnt, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    // Random requests until the total reaches the goal; many are dial-dial-field runs.
    task automatic random_traffic(input int goal);
        logic [3:0]  op;
        logic [5:0]  cnt;
        logic [5:0]  src_dial;
        logic [47:0] a;
        logic [47:0] b;
        int          pick;
        while (sent < goal)
        begin
            a = rand_word();
            b = ($urandom_range(0, 3) == 0) ? a : rand_word();
            if ($urandom_range(0, 99) < 40)
            begin
                src_dial = 6'($urandom_range(1, 63));
                send_request(CMD_DIAL_A, rand_word(), rand_word(), src_dial);
                cnt = ($urandom_range(0, 2) == 0) ? src_dial : 6'($urandom_range(1, 63));
                send_request(CMD_DIAL_B, rand_word(), rand_word(), cnt);
                op  = 4'(CMD_XFER + $urandom_range(0, 2));
                cnt = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
                send_request(op, a, b, cnt);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    op = 4'(CMD_DIAL_A + $urandom_range(0, 1));
                else if (pick < 50)
                    op = 4'(CMD_XFER + $urandom_range(0, 2));
                else if (pick < 95)
                    op = 4'(CMD_NEGATE + $urandom_range(0, 8));
                else
                    op = 4'(CMD_UNUSED_LO + $urandom_range(0, 1));
                cnt = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(0, 63));
                send_request(op, a, b, cnt);
            end
        end
    endtask

    // Reset, directed requests, four mixes of input idles and result stalls of random traffic, then the verdict.
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Full-word transfer, zero-count compares and a full-word compare at the reset dial positions.
        send_request(CMD_XFER, ALL_ONES, 48'd0, 6'd63);
        send_request(CMD_CMP_LOW, ALL_ONES, 48'd0, 6'd0);
        send_request(CMD_CMP_EQ, 48'd0, ALL_ONES, 6'd0);
        send_request(CMD_CMP_EQ, 48'h1234_5678_9ABC, 48'h1234_5678_9ABC, 6'd48);
        // A zero-count dial changes nothing, then a source dial past the word.
        send_request(CMD_DIAL_A, ALL_ONES, 48'd0, 6'd0);
        send_request(CMD_DIAL_A, 48'd0, ALL_ONES, 6'o77);
        send_request(CMD_XFER, ALL_ONES, 48'd0, 6'd5);
        send_request(CMD_CMP_LOW, ALL_ONES, 48'd0, 6'd5);
        send_request(CMD_CMP_EQ, ALL_ONES, 48'd0, 6'd5);
        // Fields that run off bit 0 and get shortened, the last to nothing with the destination past the word.
        send_request(CMD_DIAL_A, 48'd0, 48'd0, 6'o65);
        send_request(CMD_DIAL_B, 48'd0, 48'd0, 6'o71);
        send_request(CMD_XFER, ALL_ONES, 48'd0, 6'd10);
        send_request(CMD_CMP_LOW, ALL_ONES, 48'd0, 6'd63);
        send_request(CMD_DIAL_B, 48'd0, 48'd0, 6'o75);
        send_request(CMD_DIAL_B, 48'd0, 48'd0, 6'o76);
        send_request(CMD_XFER, ALL_ONES, 48'd0, 6'd3);
        // Logical, flag and sign operations and the unused codes.
        send_request(CMD_NEGATE, ALL_ONES, 48'd0, 6'd0);
        send_request(CMD_OR, 48'd0, ALL_ONES, 6'd63);
        send_request(CMD_AND, 48'd0, ALL_ONES, 6'd1);
        send_request(CMD_EQV, 48'd0, ALL_ONES, 6'd7);
        send_request(CMD_MKOP, ALL_ONES, ALL_ONES, 6'd0);
        send_request(CMD_MKDESC, 48'd0, 48'd0, 6'd0);
        send_request(CMD_SETNEG, 48'd0, ALL_ONES, 6'd0);
        send_request(CMD_CHSIGN, ALL_ONES, 48'd0, 6'd0);
        send_request(CMD_SETPOS, ALL_ONES, 48'd0, 6'd0);
        send_request(CMD_UNUSED_LO, ALL_ONES, 48'd0, 6'd63);
        send_request(CMD_UNUSED_HI, 48'd0, ALL_ONES, 6'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle  = idle_mix[phase];
            recv_stall = stall_mix[phase];
            if (phase == 0)
            begin
                // Hold the result side off while requests keep coming, to fill the pipe.
                random_traffic(sent + 150);
                hold_asks++;
            end
            random_traffic(sent + PHASE_ITEMS - ((phase == 0) ? 150 : 0));
        end
        s_tvalid <= 1'b0;

        // Drain the block before judging.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Run covered %0d requests and %0d results over four idle mixes,",
                 req_seen, res_seen);
        $display("including %0d long result hold-offs with the input stalled.", hold_done);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
